/* sv/mrt_pkg.sv */
// Package: shared types and constants for the 4x4 row transform.
package mrt_pkg;

    localparam int N_DIM     = 4;
    localparam int DATA_W    = 32;
    localparam int FRAC_BITS = 16;
    localparam int PROD_W    = 2 * DATA_W;
    localparam int SUM_W     = PROD_W - FRAC_BITS + 2;
    localparam int ROW_W     = $clog2(N_DIM);

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_MUL  = 1'b1;

    localparam logic [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    typedef logic [N_DIM-1:0][DATA_W-1:0] t_row_vec;
    typedef t_row_vec [N_DIM-1:0]         t_mat;

    typedef struct packed {
        logic                     req_type;
        logic [ROW_W-1:0]         row_index;
        logic signed [DATA_W-1:0] elem_0;
        logic signed [DATA_W-1:0] elem_1;
        logic signed [DATA_W-1:0] elem_2;
        logic signed [DATA_W-1:0] elem_3;
    } t_in_beat;

    typedef struct packed {
        logic [ROW_W-1:0]         out_row;
        logic signed [DATA_W-1:0] res_0;
        logic signed [DATA_W-1:0] res_1;
        logic signed [DATA_W-1:0] res_2;
        logic signed [DATA_W-1:0] res_3;
        logic                     saturated;
    } t_out_beat;

endpackage

/* sv/mrt_store.sv */
// Stored matrix: one row written per load beat, all entries visible.
module mrt_store (
    input  logic                  i_clk,
    input  logic                  i_we,
    input  logic [mrt_pkg::ROW_W-1:0] i_row,
    input  mrt_pkg::t_row_vec     i_data,
    output mrt_pkg::t_mat         o_mat
);

    mrt_pkg::t_mat r_mat;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mat[i_row] <= i_data;
        end
    end

    assign o_mat = r_mat;

endmodule

/* sv/mrt_lane.sv */
// Column lane: four registered products, floor shift, wide sum and saturation.
module mrt_lane (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  mrt_pkg::t_row_vec             i_a,
    input  mrt_pkg::t_row_vec             i_b,
    output logic [mrt_pkg::DATA_W-1:0]    o_res,
    output logic                          o_sat
);

    logic signed [mrt_pkg::PROD_W-1:0] r_prod [mrt_pkg::N_DIM];
    logic signed [mrt_pkg::SUM_W-1:0]  sum;
    logic [mrt_pkg::SUM_W-mrt_pkg::DATA_W:0] top_bits;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < mrt_pkg::N_DIM; k++) begin
                r_prod[k] <= mrt_pkg::PROD_W'($signed(i_a[k]))
                           * mrt_pkg::PROD_W'($signed(i_b[k]));
            end
        end
    end

    always_comb begin
        sum = '0;
        for (int k = 0; k < mrt_pkg::N_DIM; k++) begin
            sum = sum + mrt_pkg::SUM_W'(r_prod[k] >>> mrt_pkg::FRAC_BITS);
        end
    end

    assign top_bits = sum[mrt_pkg::SUM_W-1:mrt_pkg::DATA_W-1];

    always_comb begin
        if ((top_bits == '0) || (top_bits == '1)) begin
            o_res = sum[mrt_pkg::DATA_W-1:0];
            o_sat = 1'b0;
        end else begin
            o_res = sum[mrt_pkg::SUM_W-1] ? mrt_pkg::SAT_MIN : mrt_pkg::SAT_MAX;
            o_sat = 1'b1;
        end
    end

endmodule

/* sv/matrix4x4_row_transform_top.sv */
// Top level: 4x4 row transform, result row = left row x stored matrix.
//
// Input channel (i_in_valid / o_in_stall / i_in_beat): a beat with
// req_type load writes stored row row_index and yields no output; a
// beat with req_type multiply yields one output beat holding the row
// times the stored matrix, Q16.16, saturated to 32 bits per column.
// Output channel (o_out_valid / i_out_stall / o_out_beat).
// Pipeline: input register, product register in four column lanes, output
// register. Throughput: one beat per cycle while the output is not stalled,
// set by the three-stage pipe; the sixteen 32x32 products of a row form
// together in the lanes.
// Loads are applied in order with multiplies, as they leave stage one.
// Reset clears the pipe valid bits only; stored rows must be loaded
// before a multiply reads them.
// A stall on the output holds the output beat; the stages behind it
// keep filling until full, then o_in_stall rises.
module matrix4x4_row_transform_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  mrt_pkg::t_in_beat  i_in_beat,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output mrt_pkg::t_out_beat o_out_beat
);

    logic                       r_s1_v;
    logic                       r_s1_type;
    logic [mrt_pkg::ROW_W-1:0]  r_s1_row;
    mrt_pkg::t_row_vec          r_s1_a;
    logic                       r_s2_v;
    logic [mrt_pkg::ROW_W-1:0]  r_s2_row;
    logic                       r_out_v;
    mrt_pkg::t_out_beat         r_out_beat;

    logic out_rdy, s2_rdy, s2_adv, s1_rdy, s1_adv, accept;
    logic store_we, lane_en;
    mrt_pkg::t_mat     mat;
    mrt_pkg::t_row_vec in_vec;
    logic [mrt_pkg::N_DIM-1:0][mrt_pkg::DATA_W-1:0] lane_res;
    logic [mrt_pkg::N_DIM-1:0]                      lane_sat;

    assign out_rdy = !r_out_v || !i_out_stall;
    assign s2_adv  = r_s2_v && out_rdy;
    assign s2_rdy  = !r_s2_v || out_rdy;
    assign s1_adv  = r_s1_v && s2_rdy;
    assign s1_rdy  = !r_s1_v || s2_rdy;
    assign accept  = i_in_valid && s1_rdy;

    assign store_we = s1_adv && (r_s1_type == mrt_pkg::REQ_LOAD);
    assign lane_en  = s1_adv && (r_s1_type == mrt_pkg::REQ_MUL);

    assign in_vec[0] = i_in_beat.elem_0;
    assign in_vec[1] = i_in_beat.elem_1;
    assign in_vec[2] = i_in_beat.elem_2;
    assign in_vec[3] = i_in_beat.elem_3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v  <= 1'b0;
            r_s2_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (s1_rdy) begin
                r_s1_v <= i_in_valid;
            end
            if (s1_adv) begin
                r_s2_v <= (r_s1_type == mrt_pkg::REQ_MUL);
            end else if (s2_adv) begin
                r_s2_v <= 1'b0;
            end
            if (out_rdy) begin
                r_out_v <= r_s2_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_type <= i_in_beat.req_type;
            r_s1_row  <= i_in_beat.row_index;
            r_s1_a    <= in_vec;
        end
        if (lane_en) begin
            r_s2_row <= r_s1_row;
        end
        if (s2_adv) begin
            r_out_beat.out_row   <= r_s2_row;
            r_out_beat.res_0     <= lane_res[0];
            r_out_beat.res_1     <= lane_res[1];
            r_out_beat.res_2     <= lane_res[2];
            r_out_beat.res_3     <= lane_res[3];
            r_out_beat.saturated <= |lane_sat;
        end
    end

    mrt_store u_store (
        .i_clk  (i_clk),
        .i_we   (store_we),
        .i_row  (r_s1_row),
        .i_data (r_s1_a),
        .o_mat  (mat)
    );

    for (genvar c = 0; c < mrt_pkg::N_DIM; c++) begin : g_lane
        mrt_pkg::t_row_vec col;
        for (genvar k = 0; k < mrt_pkg::N_DIM; k++) begin : g_col
            assign col[k] = mat[k][c];
        end
        mrt_lane u_lane (
            .i_clk (i_clk),
            .i_en  (lane_en),
            .i_a   (r_s1_a),
            .i_b   (col),
            .o_res (lane_res[c]),
            .o_sat (lane_sat[c])
        );
    end

    assign o_in_stall  = !s1_rdy;
    assign o_out_valid = r_out_v;
    assign o_out_beat  = r_out_beat;

endmodule
